@@ src/pressure_sensor_conditioner_assert.svh @@
// assertion macros shared by the pressure sensor conditioner modules
`ifndef PRESSURE_SENSOR_CONDITIONER_ASSERT_SVH
`define PRESSURE_SENSOR_CONDITIONER_ASSERT_SVH

`ifndef ASSERT_OFF
// property checked at every clock edge outside reset
`define PSC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// condition in one cycle implies expectation in the next
`define PSC_ASSERT_NEXT(lbl, clk, rstn, cond, expct, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (expct)) \
        else $error(msg);
`else
`define PSC_ASSERT(lbl, clk, rstn, prop, msg)
`define PSC_ASSERT_NEXT(lbl, clk, rstn, cond, expct, msg)
`endif

`endif

@@ src/psc_pkg.sv @@
// shared types and constants of the pressure sensor conditioner
package psc_pkg;

    // fixed field widths
    localparam int MBAR_W     = 16;
    localparam int CFG_W      = 12;
    localparam int TIME_W     = 32;
    localparam int CMD_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int RAW_REL_W  = 17;

    // command codes on the input channel
    localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ZERO   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_START  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_STOP   = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PLAUS_MIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PLAUS_MAX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_CNT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPAN_CNT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPAN_MBAR = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET    = 3'd5;

    // configuration reset values
    localparam logic [CFG_W-1:0]  RST_PLAUS_MIN = 12'd50;
    localparam logic [CFG_W-1:0]  RST_PLAUS_MAX = 12'd4050;
    localparam logic [CFG_W-1:0]  RST_ZERO_CNT  = 12'd166;
    localparam logic [CFG_W-1:0]  RST_SPAN_CNT  = 12'd2028;
    localparam logic [MBAR_W-1:0] RST_SPAN_MBAR = 16'd500;
    localparam logic [MBAR_W-1:0] RST_TARGET    = 16'd450;

    localparam logic [MBAR_W-1:0] MBAR_MAX = 16'hFFFF;

    // item class decided by the front end
    typedef enum logic [2:0] {
        KIND_SAMPLE,
        KIND_BAD_READ,
        KIND_ZERO,
        KIND_START,
        KIND_STOP
    } kind_t;

    localparam int KIND_W = $bits(kind_t);

    // back end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_AVG,
        ST_CHECK,
        ST_MUL,
        ST_DIV,
        ST_REL,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

@@ src/psc_ram.sv @@
// generic single write port ram with registered read
module psc_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 8
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ src/psc_fifo.sv @@
// short item queue between front end and back end
`include "pressure_sensor_conditioner_assert.svh"
module psc_fifo #(
    parameter int WIDTH = 47,
    parameter int DEPTH = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  logic [WIDTH-1:0]     push_data,
    input  logic                 pop,
    output logic [WIDTH-1:0]     pop_data,
    output psc_pkg::fifo_status_t status
);
    import psc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_data     = slot_reg[rd_ptr_reg];

    // pointer and count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // item storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    `PSC_ASSERT(a_no_push_full, aclk, aresetn, push |-> !status.full, "push into full queue")
    `PSC_ASSERT(a_no_pop_empty, aclk, aresetn, pop |-> !status.empty, "pop from empty queue")
    `PSC_ASSERT_NEXT(a_count_up, aclk, aresetn, push && !pop, count_reg == CNT_W'($past(count_reg) + 1'b1), "count did not grow")

endmodule

@@ src/psc_front.sv @@
// front end: takes input items, classifies them and queues them
module psc_front #(
    parameter int ADC_BITS = 12,
    parameter int TDATA_W  = 48,
    parameter int ITEM_W   = 47
) (
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [TDATA_W-1:0]    s_tdata,
    input  logic [2:0]            s_tuser,
    input  psc_pkg::fifo_status_t fifo_st,
    output logic                  push,
    output logic [ITEM_W-1:0]     push_data
);
    import psc_pkg::*;

    logic [CMD_W-1:0]    cmd;
    logic                read_ok;
    logic [ADC_BITS-1:0] sample;
    logic [TIME_W-1:0]   now_ms;
    kind_t               kind;

    // field extraction
    assign cmd     = s_tuser[CMD_W-1:0];
    assign read_ok = s_tuser[CMD_W];
    assign sample  = s_tdata[ADC_BITS-1:0];
    assign now_ms  = s_tdata[ADC_BITS +: TIME_W];

    // command decode
    always_comb begin
        unique case (cmd)
            CMD_SAMPLE: kind = read_ok ? KIND_SAMPLE : KIND_BAD_READ;
            CMD_ZERO:   kind = KIND_ZERO;
            CMD_START:  kind = KIND_START;
            CMD_STOP:   kind = KIND_STOP;
            default:    kind = KIND_STOP;
        endcase
    end

    // queue handshake
    assign s_tready  = !fifo_st.full;
    assign push      = s_tvalid && s_tready;
    assign push_data = {kind, sample, now_ms};

endmodule

@@ src/psc_divider.sv @@
// shared restoring divider, one quotient bit per cycle
module psc_divider #(
    parameter int DW = 12
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [DW+psc_pkg::MBAR_W-1:0] num,
    input  logic [DW-1:0]                 den,
    output logic [psc_pkg::MBAR_W-1:0]    quot,
    output psc_pkg::div_status_t          status
);
    import psc_pkg::*;

    // quotient must fit MBAR_W bits: num below den shifted by MBAR_W
    localparam int QW    = MBAR_W;
    localparam int CNT_W = $clog2(QW + 1);

    logic [DW-1:0]    rem_reg, rem_next;
    logic [QW-1:0]    quo_reg, quo_next;
    logic [DW-1:0]    den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DW:0]      shifted;
    logic [DW:0]      diff;
    logic             ge;

    assign shifted = {rem_reg, quo_reg[QW-1]};
    assign diff    = shifted - {1'b0, den_reg};
    assign ge      = (shifted >= {1'b0, den_reg});

    // one trial subtraction per cycle
    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = num[DW+QW-1:QW];
            quo_next  = num[QW-1:0];
            den_next  = den;
            cnt_next  = CNT_W'(QW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = ge ? diff[DW-1:0] : shifted[DW-1:0];
            quo_next = {quo_reg[QW-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign quot        = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

@@ src/psc_back.sv @@
// back end: filter, calibration, offset and test timer sequencer
`include "pressure_sensor_conditioner_assert.svh"
module psc_back #(
    parameter int FILTER_DEPTH = 8,
    parameter int ADC_BITS     = 12,
    parameter int ITEM_W       = 47,
    parameter int OUT_W        = 128
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [psc_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [psc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  psc_pkg::fifo_status_t              fifo_st,
    input  logic [ITEM_W-1:0]                  pop_data,
    output logic                               pop,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [OUT_W-1:0]                   m_tdata
);
    import psc_pkg::*;

    localparam int IDX_W  = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;
    localparam int FILL_W = $clog2(FILTER_DEPTH + 1);
    localparam int SUM_W  = ADC_BITS + $clog2(FILTER_DEPTH);
    localparam int CALC_W = (ADC_BITS > CFG_W) ? ADC_BITS : CFG_W;
    localparam int NW     = CALC_W + MBAR_W;
    localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(FILTER_DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(FILTER_DEPTH);

    // configuration registers
    logic [CFG_W-1:0]  min_reg, max_reg, zero_reg, span_pt_reg;
    logic [MBAR_W-1:0] span_mbar_reg, target_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg       <= RST_PLAUS_MIN;
            max_reg       <= RST_PLAUS_MAX;
            zero_reg      <= RST_ZERO_CNT;
            span_pt_reg   <= RST_SPAN_CNT;
            span_mbar_reg <= RST_SPAN_MBAR;
            target_reg    <= RST_TARGET;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_PLAUS_MIN: min_reg       <= cfg_wdata[CFG_W-1:0];
                CFG_PLAUS_MAX: max_reg       <= cfg_wdata[CFG_W-1:0];
                CFG_ZERO_CNT:  zero_reg      <= cfg_wdata[CFG_W-1:0];
                CFG_SPAN_CNT:  span_pt_reg   <= cfg_wdata[CFG_W-1:0];
                CFG_SPAN_MBAR: span_mbar_reg <= cfg_wdata[MBAR_W-1:0];
                CFG_TARGET:    target_reg    <= cfg_wdata[MBAR_W-1:0];
                default: ;
            endcase
        end
    end

    state_t              state_reg, state_next;
    logic [ADC_BITS-1:0] smp_reg, smp_next;
    logic [TIME_W-1:0]   now_reg, now_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [ADC_BITS-1:0] raw_reg, raw_next;
    logic [ADC_BITS-1:0] filt_reg, filt_next;
    logic [MBAR_W-1:0]   fact_reg, fact_next;
    logic [MBAR_W-1:0]   rel_reg, rel_next;
    logic [MBAR_W-1:0]   off_reg, off_next;
    logic [TIME_W-1:0]   start_reg, start_next;
    logic [TIME_W-1:0]   elapsed_reg, elapsed_next;
    logic                valid_reg, valid_next;
    logic                active_reg, active_next;
    logic                reached_reg, reached_next;
    logic [NW-1:0]       prod_reg, prod_next;
    logic                zcase_reg, zcase_next;
    logic                out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]    out_data_reg, out_data_next;

    // ring storage for the moving average
    logic                ram_we, ram_re;
    logic [ADC_BITS-1:0] ram_rdata;

    psc_ram #(
        .WIDTH (ADC_BITS),
        .DEPTH (FILTER_DEPTH)
    ) u_ring (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (smp_reg),
        .re    (ram_re),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    // shared divider for the average and the calibration
    logic              div_start;
    logic [NW-1:0]     div_num;
    logic [CALC_W-1:0] div_den;
    logic [MBAR_W-1:0] div_quot;
    div_status_t       div_st;

    psc_divider #(
        .DW (CALC_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .quot    (div_quot),
        .status  (div_st)
    );

    // item fields out of the queue
    kind_t               q_kind;
    logic [ADC_BITS-1:0] q_smp;
    logic [TIME_W-1:0]   q_now;

    assign q_kind = kind_t'(pop_data[ITEM_W-1 -: KIND_W]);
    assign q_smp  = pop_data[TIME_W +: ADC_BITS];
    assign q_now  = pop_data[TIME_W-1:0];

    // ring update: a slot not yet filled reads as zero
    logic [ADC_BITS-1:0] old_smp;
    logic [SUM_W-1:0]    sum_upd;
    logic [FILL_W-1:0]   fill_upd;
    logic [IDX_W-1:0]    idx_upd;

    assign old_smp  = (fill_reg == FILL_MAX) ? ram_rdata : '0;
    assign sum_upd  = sum_reg - SUM_W'(old_smp) + SUM_W'(smp_reg);
    assign fill_upd = (fill_reg == FILL_MAX) ? fill_reg : fill_reg + 1'b1;
    assign idx_upd  = (idx_reg == IDX_LAST) ? '0 : idx_reg + 1'b1;

    // plausibility and calibration terms
    logic [CALC_W-1:0] filt_ext, zero_ext, span_pt_ext, span;
    logic [CALC_W-1:0] delta;
    logic              in_lim, zcase;
    logic [NW-1:0]     prod_w;
    logic [NW:0]       num_w;
    logic              sat;

    assign filt_ext    = CALC_W'(filt_reg);
    assign zero_ext    = CALC_W'(zero_reg);
    assign span_pt_ext = CALC_W'(span_pt_reg);
    assign span        = span_pt_ext - zero_ext;
    assign delta       = filt_ext - zero_ext;
    assign in_lim      = (filt_ext >= CALC_W'(min_reg)) && (filt_ext <= CALC_W'(max_reg));
    assign zcase       = (filt_ext <= zero_ext) || (span_pt_ext <= zero_ext);
    assign prod_w      = NW'(delta) * NW'(span_mbar_reg);
    assign num_w       = (NW+1)'(prod_reg) + (NW+1)'(span >> 1);
    assign sat         = (num_w >= (NW+1)'({span, {MBAR_W{1'b0}}}));

    // relative pressure and result word
    logic [MBAR_W-1:0]    rel_w;
    logic [RAW_REL_W-1:0] raw_rel;

    assign rel_w   = (fact_reg > off_reg) ? fact_reg - off_reg : '0;
    assign raw_rel = {1'b0, fact_reg} - {1'b0, off_reg};

    // sequencer
    always_comb begin
        state_next     = state_reg;
        smp_next       = smp_reg;
        now_next       = now_reg;
        sum_next       = sum_reg;
        idx_next       = idx_reg;
        fill_next      = fill_reg;
        raw_next       = raw_reg;
        filt_next      = filt_reg;
        fact_next      = fact_reg;
        rel_next       = rel_reg;
        off_next       = off_reg;
        start_next     = start_reg;
        elapsed_next   = elapsed_reg;
        valid_next     = valid_reg;
        active_next    = active_reg;
        reached_next   = reached_reg;
        prod_next      = prod_reg;
        zcase_next     = zcase_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        pop            = 1'b0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        div_start      = 1'b0;
        div_num        = num_w[NW-1:0];
        div_den        = span;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (!fifo_st.empty && !out_valid_reg) begin
                    pop        = 1'b1;
                    state_next = ST_OUT;
                    unique case (q_kind)
                        KIND_SAMPLE: begin
                            ram_re     = 1'b1;
                            smp_next   = q_smp;
                            now_next   = q_now;
                            state_next = ST_READ;
                        end
                        KIND_BAD_READ: begin
                            valid_next = 1'b0;
                        end
                        KIND_ZERO: begin
                            off_next = valid_reg ? fact_reg : '0;
                            rel_next = '0;
                        end
                        KIND_START: begin
                            off_next     = valid_reg ? fact_reg : '0;
                            rel_next     = '0;
                            active_next  = 1'b1;
                            reached_next = 1'b0;
                            elapsed_next = '0;
                            start_next   = q_now;
                        end
                        KIND_STOP: begin
                            active_next = 1'b0;
                        end
                        default: begin
                            active_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_READ: begin
                ram_we     = 1'b1;
                sum_next   = sum_upd;
                fill_next  = fill_upd;
                idx_next   = idx_upd;
                raw_next   = smp_reg;
                div_start  = 1'b1;
                div_num    = NW'(sum_upd);
                div_den    = CALC_W'(fill_upd);
                state_next = ST_AVG;
            end
            ST_AVG: begin
                if (div_st.done) begin
                    filt_next  = div_quot[ADC_BITS-1:0];
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                valid_next = in_lim;
                prod_next  = prod_w;
                zcase_next = zcase;
                state_next = in_lim ? ST_MUL : ST_OUT;
            end
            ST_MUL: begin
                if (zcase_reg) begin
                    fact_next  = '0;
                    state_next = ST_REL;
                end else if (sat) begin
                    fact_next  = MBAR_MAX;
                    state_next = ST_REL;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_st.done) begin
                    fact_next  = div_quot;
                    state_next = ST_REL;
                end
            end
            ST_REL: begin
                rel_next = rel_w;
                if (active_reg && !reached_reg && (rel_w >= target_reg)) begin
                    reached_next = 1'b1;
                    elapsed_next = now_reg - start_reg;
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                out_valid_next = 1'b1;
                out_data_next  = OUT_W'({elapsed_reg, reached_reg, active_reg, raw_rel,
                                         rel_reg, off_reg, fact_reg, valid_reg,
                                         filt_reg, raw_reg});
                state_next     = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and visible state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            sum_reg       <= '0;
            idx_reg       <= '0;
            fill_reg      <= '0;
            raw_reg       <= '0;
            filt_reg      <= '0;
            fact_reg      <= '0;
            rel_reg       <= '0;
            off_reg       <= '0;
            start_reg     <= '0;
            elapsed_reg   <= '0;
            valid_reg     <= 1'b0;
            active_reg    <= 1'b0;
            reached_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            idx_reg       <= idx_next;
            fill_reg      <= fill_next;
            raw_reg       <= raw_next;
            filt_reg      <= filt_next;
            fact_reg      <= fact_next;
            rel_reg       <= rel_next;
            off_reg       <= off_next;
            start_reg     <= start_next;
            elapsed_reg   <= elapsed_next;
            valid_reg     <= valid_next;
            active_reg    <= active_next;
            reached_reg   <= reached_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working payload
    always_ff @(posedge aclk) begin
        smp_reg      <= smp_next;
        now_reg      <= now_next;
        prod_reg     <= prod_next;
        zcase_reg    <= zcase_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `PSC_ASSERT(a_fill_bound, aclk, aresetn, fill_reg <= FILL_MAX, "fill count beyond filter depth")
    `PSC_ASSERT(a_div_free, aclk, aresetn, div_start |-> !div_st.busy, "divider started while busy")
    `PSC_ASSERT_NEXT(a_out_load, aclk, aresetn, state_reg == ST_OUT, out_valid_reg && (state_reg == ST_IDLE), "result not loaded")

endmodule

@@ src/pressure_sensor_conditioner.sv @@
// top level of the pressure sensor conditioner
// Each input item is a sample or a command (capture zero, start test, stop
// test); every item yields exactly one result item showing the state after
// it. The front end queues up to QUEUE_DEPTH items while the back end works.
// A good, plausible sample passes the back end as a ring read, two 16-step
// divisions on the one shared serial divider (average, then calibration) and
// the check, scaling and output states; a saturated or zero calibration
// skips the second division. Failed reads and commands go from idle straight
// to the output state. The result register must be empty before the back end
// takes the next item, so a stalled result channel holds the back end while
// the queue keeps filling. No clearing pass is needed after reset: the fill
// count masks ring slots not yet written.
module pressure_sensor_conditioner #(
    parameter int FILTER_DEPTH = 8,
    parameter int ADC_BITS     = 12,
    parameter int QUEUE_DEPTH  = 4
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration write port
    input  logic                               cfg_we,
    input  logic [psc_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [psc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // input items
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // adc_sample, now_ms, zero fill
    input  logic [((ADC_BITS+psc_pkg::TIME_W+7)/8)*8-1:0] s_tdata,
    // cmd, read_ok
    input  logic [2:0]                         s_tuser,
    // result items
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // raw_counts, filtered_counts, valid_res, factory_mbar, zero_offset,
    // relative_mbar, raw_relative, test_active, target_reached,
    // time_to_target, zero fill
    output logic [((2*ADC_BITS+100+7)/8)*8-1:0] m_tdata
);
    import psc_pkg::*;

    localparam int TDATA_W = ((ADC_BITS + TIME_W + 7) / 8) * 8;
    localparam int OUT_W   = ((2 * ADC_BITS + 100 + 7) / 8) * 8;
    localparam int ITEM_W  = KIND_W + ADC_BITS + TIME_W;

    logic              push, pop;
    logic [ITEM_W-1:0] push_data, pop_data;
    fifo_status_t      fifo_st;

    psc_front #(
        .ADC_BITS (ADC_BITS),
        .TDATA_W  (TDATA_W),
        .ITEM_W   (ITEM_W)
    ) u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .fifo_st   (fifo_st),
        .push      (push),
        .push_data (push_data)
    );

    psc_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (fifo_st)
    );

    psc_back #(
        .FILTER_DEPTH (FILTER_DEPTH),
        .ADC_BITS     (ADC_BITS),
        .ITEM_W       (ITEM_W),
        .OUT_W        (OUT_W)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .fifo_st   (fifo_st),
        .pop_data  (pop_data),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
